// File: rtl/alwc_pkg.sv
// ----------------------------------------------------------------------------
// alwc_pkg
// Shared constants and controller/datapath interface types for the
// whitespace compactor.
// ----------------------------------------------------------------------------
`default_nettype none

package alwc_pkg;

  // Held whitespace store in the quoted tail
  localparam int unsigned HeldDepth = 63;
  localparam int unsigned HeldCntW  = 6;

  // Character codes
  localparam logic [7:0] ChNul    = 8'd0;
  localparam logic [7:0] ChTab    = 8'd9;
  localparam logic [7:0] ChNl     = 8'd10;
  localparam logic [7:0] ChSpace  = 8'd32;
  localparam logic [7:0] ChQuote  = 8'd34;
  localparam logic [7:0] ChLParen = 8'd40;
  localparam logic [7:0] ChRParen = 8'd41;
  localparam logic [7:0] ChComma  = 8'd44;
  localparam logic [7:0] ChEof    = 8'd255;

  // Controller -> datapath
  typedef struct packed {
    logic accept;
    logic emit_flush;
    logic emit_pre;
    logic emit_main;
  } alwc_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic dec_flush;   // incoming byte needs a flush of held whitespace
    logic dec_pre;     // incoming byte needs a prefix byte
    logic dec_main;    // incoming byte needs a main byte
    logic plan_pre;    // registered plan of the current transfer
    logic plan_main;
    logic held_last;   // one held byte left
    logic slot_free;   // output register can load this cycle
  } alwc_sts_t;

endpackage

`default_nettype wire

// File: rtl/alwc_dp.sv
// ----------------------------------------------------------------------------
// alwc_dp
// Datapath: line state, byte decode, held whitespace store and the output
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module alwc_dp (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [7:0]          in_char_i,
  input  wire alwc_pkg::alwc_cmd_t cmd_i,
  output alwc_pkg::alwc_sts_t      sts_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [7:0]               out_char_o,
  output logic                     last_of_run_o,
  output logic                     overrun_o
);

  // Line state
  logic space_q, space_d;
  logic comma_q, comma_d;
  logic token_q, token_d;
  logic quoted_q, quoted_d;

  // Held whitespace store
  logic [alwc_pkg::HeldCntW-1:0]  cnt_q, cnt_d;
  logic [alwc_pkg::HeldDepth-1:0] tab_q, tab_d;

  // Plan of the accepted byte
  logic       plan_pre_q, plan_main_q, plan_ov_q, plan_hold_q, plan_tab_q;
  logic [7:0] pre_char_q, main_char_q;

  // Output register
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_char_q, out_char_d;
  logic       out_last_q, out_last_d;
  logic       out_ov_q, out_ov_d;

  // Decode
  logic       is_eol, is_ws, is_tab, is_paren;
  logic       dec_flush, dec_pre, dec_main, dec_ov, dec_hold, held_clear, rearm;
  logic [7:0] pre_char, main_char;
  logic       load;

  assign is_eol   = (in_char_i == alwc_pkg::ChNl) || (in_char_i == alwc_pkg::ChEof) ||
                    (in_char_i == alwc_pkg::ChNul);
  assign is_tab   = (in_char_i == alwc_pkg::ChTab);
  assign is_ws    = is_tab || (in_char_i == alwc_pkg::ChSpace);
  assign is_paren = (in_char_i == alwc_pkg::ChLParen) || (in_char_i == alwc_pkg::ChRParen);

  // Per-byte decision and next line state
  always_comb begin
    space_d    = space_q;
    comma_d    = comma_q;
    token_d    = token_q;
    quoted_d   = quoted_q;
    dec_flush  = 1'b0;
    dec_pre    = 1'b0;
    dec_main   = 1'b0;
    dec_ov     = 1'b0;
    dec_hold   = 1'b0;
    held_clear = 1'b0;
    rearm      = 1'b0;
    pre_char   = alwc_pkg::ChSpace;
    main_char  = in_char_i;
    if (is_eol) begin
      dec_pre    = comma_q;
      pre_char   = alwc_pkg::ChComma;
      dec_main   = 1'b1;
      main_char  = alwc_pkg::ChNl;
      space_d    = 1'b0;
      comma_d    = 1'b0;
      token_d    = 1'b0;
      quoted_d   = 1'b0;
      held_clear = 1'b1;
    end else if (quoted_q) begin
      if (is_ws) begin
        dec_hold = 1'b1;
        if (cnt_q == alwc_pkg::HeldCntW'(alwc_pkg::HeldDepth)) begin
          dec_flush = 1'b1;
          dec_ov    = 1'b1;
        end
      end else begin
        dec_flush = (cnt_q != '0);
        dec_main  = 1'b1;
      end
    end else if (is_ws) begin
      // leading whitespace sets nothing
      space_d = token_q;
    end else if (in_char_i == alwc_pkg::ChComma) begin
      if (!comma_q) begin
        comma_d = 1'b1;
      end else begin
        // second comma goes out at once, the pending one stays
        dec_main = 1'b1;
        space_d  = 1'b0;
      end
    end else begin
      if (comma_q) begin
        dec_pre  = 1'b1;
        pre_char = alwc_pkg::ChComma;
        comma_d  = 1'b0;
        space_d  = 1'b0;
      end else if (space_q) begin
        if (is_paren) begin
          rearm = 1'b1;
        end else begin
          dec_pre = 1'b1;
        end
        space_d = 1'b0;
      end
      dec_main = 1'b1;
      if (in_char_i == alwc_pkg::ChQuote) begin
        quoted_d = 1'b1;
      end else begin
        token_d = !rearm;
      end
    end
  end

  // Held store: append or clear on transfer, shift out on flush
  always_comb begin
    cnt_d = cnt_q;
    tab_d = tab_q;
    if (cmd_i.accept) begin
      if (held_clear) begin
        cnt_d = '0;
        tab_d = '0;
      end else if (dec_hold && !dec_flush) begin
        tab_d[cnt_q] = is_tab;
        cnt_d        = cnt_q + alwc_pkg::HeldCntW'(1);
      end
    end else if (cmd_i.emit_flush) begin
      tab_d = tab_q >> 1;
      cnt_d = cnt_q - alwc_pkg::HeldCntW'(1);
      if (sts_o.held_last && plan_hold_q) begin
        // byte that found the store full is held after the flush
        tab_d[0] = plan_tab_q;
        cnt_d    = alwc_pkg::HeldCntW'(1);
      end
    end
  end

  // Output register load
  assign load = cmd_i.emit_flush || cmd_i.emit_pre || cmd_i.emit_main;

  always_comb begin
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    out_ov_d    = out_ov_q;
    out_valid_d = out_ready_i ? 1'b0 : out_valid_q;
    if (cmd_i.emit_flush) begin
      out_char_d = tab_q[0] ? alwc_pkg::ChTab : alwc_pkg::ChSpace;
      out_last_d = sts_o.held_last && !plan_pre_q && !plan_main_q;
      out_ov_d   = plan_ov_q;
    end else if (cmd_i.emit_pre) begin
      out_char_d = pre_char_q;
      out_last_d = !plan_main_q;
      out_ov_d   = 1'b0;
    end else if (cmd_i.emit_main) begin
      out_char_d = main_char_q;
      out_last_d = 1'b1;
      out_ov_d   = 1'b0;
    end
    if (load) begin
      out_valid_d = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      space_q     <= 1'b0;
      comma_q     <= 1'b0;
      token_q     <= 1'b0;
      quoted_q    <= 1'b0;
      cnt_q       <= '0;
      tab_q       <= '0;
      plan_pre_q  <= 1'b0;
      plan_main_q <= 1'b0;
      plan_hold_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      tab_q       <= tab_d;
      out_valid_q <= out_valid_d;
      if (cmd_i.accept) begin
        space_q     <= space_d;
        comma_q     <= comma_d;
        token_q     <= token_d;
        quoted_q    <= quoted_d;
        plan_pre_q  <= dec_pre;
        plan_main_q <= dec_main;
        plan_hold_q <= dec_hold && dec_flush;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
    out_ov_q   <= out_ov_d;
    if (cmd_i.accept) begin
      plan_ov_q   <= dec_ov;
      plan_tab_q  <= is_tab;
      pre_char_q  <= pre_char;
      main_char_q <= main_char;
    end
  end

  // Status
  assign sts_o.dec_flush = dec_flush;
  assign sts_o.dec_pre   = dec_pre;
  assign sts_o.dec_main  = dec_main;
  assign sts_o.plan_pre  = plan_pre_q;
  assign sts_o.plan_main = plan_main_q;
  assign sts_o.held_last = (cnt_q == alwc_pkg::HeldCntW'(1));
  assign sts_o.slot_free = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign out_char_o    = out_char_q;
  assign last_of_run_o = out_last_q;
  assign overrun_o     = out_ov_q;

endmodule

`default_nettype wire

// File: rtl/alwc_ctrl.sv
// ----------------------------------------------------------------------------
// alwc_ctrl
// Controller: takes one byte at a time and sequences its results
// (held flush, prefix byte, main byte) into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module alwc_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire alwc_pkg::alwc_sts_t sts_i,
  output alwc_pkg::alwc_cmd_t      cmd_o
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StFlush = 2'd1;
  localparam logic [1:0] StPre   = 2'd2;
  localparam logic [1:0] StMain  = 2'd3;

  logic [1:0] state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.dec_flush) begin
            state_d = StFlush;
          end else if (sts_i.dec_pre) begin
            state_d = StPre;
          end else if (sts_i.dec_main) begin
            state_d = StMain;
          end
        end
      end
      StFlush: begin
        if (sts_i.slot_free) begin
          cmd_o.emit_flush = 1'b1;
          if (sts_i.held_last) begin
            if (sts_i.plan_pre) begin
              state_d = StPre;
            end else if (sts_i.plan_main) begin
              state_d = StMain;
            end else begin
              state_d = StIdle;
            end
          end
        end
      end
      StPre: begin
        if (sts_i.slot_free) begin
          cmd_o.emit_pre = 1'b1;
          state_d = sts_i.plan_main ? StMain : StIdle;
        end
      end
      StMain: begin
        if (sts_i.slot_free) begin
          cmd_o.emit_main = 1'b1;
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/assembly_line_whitespace_compactor_core.sv
// ----------------------------------------------------------------------------
// assembly_line_whitespace_compactor_core
// Normalizes assembly source lines one byte at a time.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i/in_ready_o carries one source byte per transfer.
//   Output channel out_valid_o/out_ready_i carries one normalized byte per
//   transfer; last_of_run_o marks the final byte caused by an input byte and
//   overrun_o marks quoted whitespace flushed because the 63-entry hold store
//   was full. Bytes 10, 255 and 0 close the line with an optional comma and
//   a newline.
//   Timing: a byte that produces nothing is taken in the idle state; a byte
//   producing n results then loads them into the output register, one result
//   per cycle while the receiver does not stall, up to 63 held bytes for a
//   flush. The result sequencer is the limit: one output register load per
//   cycle, unless stalled. The input transfer moves the controller to its
//   flush, prefix or main state, which loads the first result.
//   When the receiver stalls, the output register holds its byte and the
//   sequencer waits; a new input byte is taken only after all results of the
//   previous one are loaded.
//   Reset (rst_ni low, asynchronous) clears the line state, the hold store
//   and the output valid; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module assembly_line_whitespace_compactor_core (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_char_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_char_o,
  output logic            last_of_run_o,
  output logic            overrun_o
);

  alwc_pkg::alwc_cmd_t cmd;
  alwc_pkg::alwc_sts_t sts;

  alwc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  alwc_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_char_i     (in_char_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_char_o    (out_char_o),
    .last_of_run_o (last_of_run_o),
    .overrun_o     (overrun_o)
  );

  // A newline only closes a line, so it always ends its run
  a_nl_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_char_o == alwc_pkg::ChNl)) |-> last_of_run_o)
    else $error("newline not marked last");

  // Overrun flushes carry whitespace only
  a_ov_ws : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && overrun_o) |->
      ((out_char_o == alwc_pkg::ChSpace) || (out_char_o == alwc_pkg::ChTab)))
    else $error("overrun on non-whitespace byte");

  // A stalled output transfer keeps its byte and flags
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(out_char_o) && $stable(last_of_run_o) &&
       $stable(overrun_o)))
    else $error("output changed while stalled");

endmodule

`default_nettype wire

// File: bench/tb_assembly_line_whitespace_compactor_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_assembly_line_whitespace_compactor_core
// Self-checking bench for the whitespace compactor. A directed table walks
// line ends, leading and inner whitespace, commas, parentheses and the quoted
// tail; random lines follow, including long quoted whitespace runs that fill
// the hold store. Every output transfer is compared against a behavioral
// predictor of the compactor, under four source/sink idling phases.
// ----------------------------------------------------------------------------

module tb_assembly_line_whitespace_compactor_core;

  localparam int CycleLimit = 500000;
  localparam int DrainCycles = 100;
  localparam int ItemsPerPhase = 60;
  localparam int NumDir = 28;
  // Row marker: expected bytes come from the predictor, not the table
  localparam logic [1:0] Predicted = 2'd3;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       ovr;
  } out_byte_t;

  typedef struct packed {
    logic [7:0] stim;
    logic [1:0] n_fix;
    logic [7:0] r0;
    logic [7:0] r1;
  } row_t;

  // Directed rows: typed results only where obvious
  localparam row_t DirRows [NumDir] = '{
    '{alwc_pkg::ChNl,     2'd1,      alwc_pkg::ChNl,    8'h00},  // line end after reset
    '{alwc_pkg::ChEof,    2'd1,      alwc_pkg::ChNl,    8'h00},
    '{alwc_pkg::ChNul,    2'd1,      alwc_pkg::ChNl,    8'h00},
    '{alwc_pkg::ChSpace,  2'd0,      8'h00,             8'h00},  // leading ws dropped
    '{alwc_pkg::ChTab,    2'd0,      8'h00,             8'h00},
    '{8'h01,              2'd1,      8'h01,             8'h00},
    '{alwc_pkg::ChSpace,  Predicted, 8'h00,             8'h00},
    '{8'hfe,              Predicted, 8'h00,             8'h00},
    '{alwc_pkg::ChTab,    Predicted, 8'h00,             8'h00},
    '{alwc_pkg::ChLParen, Predicted, 8'h00,             8'h00},  // space dropped, re-arm
    '{alwc_pkg::ChSpace,  Predicted, 8'h00,             8'h00},
    '{"m",                Predicted, 8'h00,             8'h00},
    '{alwc_pkg::ChComma,  Predicted, 8'h00,             8'h00},
    '{alwc_pkg::ChSpace,  Predicted, 8'h00,             8'h00},
    '{alwc_pkg::ChComma,  Predicted, 8'h00,             8'h00},  // second comma at once
    '{alwc_pkg::ChTab,    Predicted, 8'h00,             8'h00},
    '{alwc_pkg::ChRParen, Predicted, 8'h00,             8'h00},  // pending comma, no re-arm
    '{alwc_pkg::ChComma,  Predicted, 8'h00,             8'h00},
    '{alwc_pkg::ChNul,    2'd2,      alwc_pkg::ChComma, alwc_pkg::ChNl},  // comma, newline
    '{"d",                Predicted, 8'h00,             8'h00},
    '{alwc_pkg::ChQuote,  Predicted, 8'h00,             8'h00},
    '{alwc_pkg::ChSpace,  Predicted, 8'h00,             8'h00},
    '{alwc_pkg::ChTab,    Predicted, 8'h00,             8'h00},
    '{alwc_pkg::ChQuote,  Predicted, 8'h00,             8'h00},  // quote in quoted tail
    '{alwc_pkg::ChSpace,  Predicted, 8'h00,             8'h00},
    '{8'h7f,              Predicted, 8'h00,             8'h00},
    '{alwc_pkg::ChTab,    Predicted, 8'h00,             8'h00},
    '{alwc_pkg::ChNl,     Predicted, 8'h00,             8'h00}   // held trailing tab dropped
  };

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [7:0] in_char_i = 8'h00;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] out_char_o;
  logic       last_of_run_o;
  logic       overrun_o;

  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  int items_sent = 0;
  int mismatches = 0;
  int cycles = 0;

  out_byte_t expected_q[$];
  out_byte_t step_res[$];

  // Predictor line state
  logic                           sp_pend;
  logic                           cm_pend;
  logic                           tok_seen;
  logic                           quoted;
  logic [alwc_pkg::HeldCntW-1:0]  held_cnt;
  logic [alwc_pkg::HeldDepth-1:0] held_tab;

  assembly_line_whitespace_compactor_core i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .in_char_i,
    .out_valid_o,
    .out_ready_i,
    .out_char_o,
    .last_of_run_o,
    .overrun_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("assembly_line_whitespace_compactor_core: mismatch");
      $finish;
    end
  end

  // Sink backpressure
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= snk_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic void clear_line();
    sp_pend  = 1'b0;
    cm_pend  = 1'b0;
    tok_seen = 1'b0;
    quoted   = 1'b0;
    held_cnt = '0;
    held_tab = '0;
  endfunction

  function automatic void put_res(input logic [7:0] ch, input logic ovr);
    step_res.push_back('{ch: ch, last: 1'b0, ovr: ovr});
  endfunction

  function automatic void flush_held(input logic ovr);
    for (int i = 0; i < int'(held_cnt); i++) begin
      put_res(held_tab[i] ? alwc_pkg::ChTab : alwc_pkg::ChSpace, ovr);
    end
    held_cnt = '0;
    held_tab = '0;
  endfunction

  // Fills step_res with the bytes one source byte produces
  function automatic void compact_char(input logic [7:0] c);
    logic ws;
    logic paren;
    logic rearm;
    step_res.delete();
    ws = (c == alwc_pkg::ChSpace) || (c == alwc_pkg::ChTab);
    if (c == alwc_pkg::ChNl || c == alwc_pkg::ChEof || c == alwc_pkg::ChNul) begin
      if (cm_pend) put_res(alwc_pkg::ChComma, 1'b0);
      put_res(alwc_pkg::ChNl, 1'b0);
      clear_line();
    end else if (quoted) begin
      if (ws) begin
        // store full: flush everything held before holding this one
        if (held_cnt >= alwc_pkg::HeldDepth) flush_held(1'b1);
        if (c == alwc_pkg::ChTab) held_tab[held_cnt] = 1'b1;
        held_cnt = held_cnt + 1'b1;
      end else begin
        flush_held(1'b0);
        put_res(c, 1'b0);
      end
    end else if (ws) begin
      sp_pend = tok_seen;
    end else if (c == alwc_pkg::ChComma) begin
      if (!cm_pend) begin
        cm_pend = 1'b1;
      end else begin
        put_res(alwc_pkg::ChComma, 1'b0);
        sp_pend = 1'b0;
      end
    end else begin
      paren = (c == alwc_pkg::ChLParen) || (c == alwc_pkg::ChRParen);
      rearm = 1'b0;
      if (cm_pend) begin
        put_res(alwc_pkg::ChComma, 1'b0);
        cm_pend = 1'b0;
        sp_pend = 1'b0;
      end else if (sp_pend) begin
        if (paren) rearm = 1'b1;
        else put_res(alwc_pkg::ChSpace, 1'b0);
        sp_pend = 1'b0;
      end
      if (c == alwc_pkg::ChQuote) begin
        put_res(alwc_pkg::ChQuote, 1'b0);
        quoted = 1'b1;
      end else begin
        put_res(c, 1'b0);
        tok_seen = !rearm;
      end
    end
    if (step_res.size() > 0) step_res[step_res.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Source side
  // ---------------------------------------------------------------------------
  task automatic send_row(input row_t r);
    int k;
    if ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_char_i  <= r.stim;
    do @(posedge clk_i); while (!in_ready_o);
    // transfer taken at this edge
    compact_char(r.stim);
    if (r.n_fix == Predicted) begin
      foreach (step_res[i]) expected_q.push_back(step_res[i]);
    end else begin
      for (k = 0; k < int'(r.n_fix); k++) begin
        expected_q.push_back('{ch: (k == 0) ? r.r0 : r.r1,
                               last: (k == int'(r.n_fix) - 1), ovr: 1'b0});
      end
    end
    items_sent++;
  endtask

  task automatic send_char(input logic [7:0] c);
    send_row('{stim: c, n_fix: Predicted, r0: 8'h00, r1: 8'h00});
  endtask

  function automatic logic [7:0] rand_ws();
    return $urandom_range(1) ? alwc_pkg::ChTab : alwc_pkg::ChSpace;
  endfunction

  // One source line; long_run > 0 forces a quoted tail opening with that
  // many whitespace bytes
  task automatic send_line(input int long_run);
    int n_tok;
    int k;
    int sel;
    repeat ($urandom_range(2)) send_char(rand_ws());
    n_tok = $urandom_range(1, 8);
    for (k = 0; k < n_tok; k++) begin
      sel = $urandom_range(99);
      if (sel < 35) send_char(8'($urandom_range(33, 126)));
      else if (sel < 55) repeat ($urandom_range(1, 3)) send_char(rand_ws());
      else if (sel < 70) send_char(alwc_pkg::ChComma);
      else if (sel < 82) send_char($urandom_range(1) ? alwc_pkg::ChLParen
                                                     : alwc_pkg::ChRParen);
      else if (sel < 90) send_char(alwc_pkg::ChQuote);
      else send_char(8'($urandom_range(255)));  // raw noise, may end the line
    end
    if (long_run > 0 || $urandom_range(3) == 0) begin
      send_char(alwc_pkg::ChQuote);
      if (long_run > 0) begin
        repeat (long_run) send_char(rand_ws());
        send_char(8'($urandom_range(33, 126)));
      end
      n_tok = $urandom_range(1, 6);
      for (k = 0; k < n_tok; k++) begin
        if ($urandom_range(1)) repeat ($urandom_range(1, 4)) send_char(rand_ws());
        else send_char(8'($urandom_range(1, 254)));
      end
    end
    sel = $urandom_range(4);
    send_char(sel == 0 ? alwc_pkg::ChEof : (sel == 1 ? alwc_pkg::ChNul : alwc_pkg::ChNl));
  endtask

  // ---------------------------------------------------------------------------
  // Output checker
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_out
    out_byte_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        $display("%0t: output %02h with nothing expected", $time, out_char_o);
        mismatches++;
      end else begin
        want = expected_q.pop_front();
        if (out_char_o !== want.ch) begin
          $display("%0t: out_char expected %02h got %02h", $time, want.ch, out_char_o);
          mismatches++;
        end
        if (last_of_run_o !== want.last) begin
          $display("%0t: last_of_run expected %b got %b", $time, want.last, last_of_run_o);
          mismatches++;
        end
        if (overrun_o !== want.ovr) begin
          $display("%0t: overrun expected %b got %b", $time, want.ovr, overrun_o);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    int ph;
    int base;
    clear_line();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    for (int i = 0; i < NumDir; i++) send_row(DirRows[i]);

    // Random lines under four idling phases
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          src_idle_pct = 0;
          snk_stall_pct = 0;
        end
        1: begin
          src_idle_pct = 65;
          snk_stall_pct = 0;
        end
        2: begin
          src_idle_pct = 0;
          snk_stall_pct = 65;
        end
        default: begin
          src_idle_pct = 9;
          snk_stall_pct = 9;
        end
      endcase
      base = items_sent;
      // store overflow under sink stalls, exact fill near the end
      if (ph == 2) send_line($urandom_range(64, 66));
      else if (ph == 3) send_line($urandom_range(60, 63));
      while (items_sent - base < ItemsPerPhase) send_line(0);
    end
    in_valid_i <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("assembly_line_whitespace_compactor_core: match");
    end else begin
      $display("assembly_line_whitespace_compactor_core: mismatch");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/alwc_pkg.sv
rtl/alwc_dp.sv
rtl/alwc_ctrl.sv
rtl/assembly_line_whitespace_compactor_core.sv
bench/tb_assembly_line_whitespace_compactor_core.sv
